[rtl/bdl_pkg.sv]
// Shared types, codes and defaults of the bounded double-ended list.
package bdl_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int OCC_W_DEF       = $clog2(CAPACITY_DEF + 1);

    localparam int KIND_W = 3;
    localparam int OPV_W  = 32;
    localparam int STAT_W = 2;
    localparam int CMD_W  = 3;

    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [STAT_W-1:0] t_status;
    typedef logic [CMD_W-1:0]  t_cmd;

    // Operation codes carried by an input beat.
    localparam t_kind K_PUSH_HEAD  = 3'd0;
    localparam t_kind K_PUSH_TAIL  = 3'd1;
    localparam t_kind K_ORD_INSERT = 3'd2;
    localparam t_kind K_POP_HEAD   = 3'd3;
    localparam t_kind K_POP_TAIL   = 3'd4;
    localparam t_kind K_REMOVE     = 3'd5;
    localparam t_kind K_QUERY      = 3'd6;

    // Result status codes.
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    // Commands broadcast to every cell of the chain.
    localparam t_cmd CMD_HOLD      = 3'd0;
    localparam t_cmd CMD_INS_HEAD  = 3'd1;
    localparam t_cmd CMD_INS_COUNT = 3'd2;
    localparam t_cmd CMD_INS_FIRST = 3'd3;
    localparam t_cmd CMD_DEL_HEAD  = 3'd4;
    localparam t_cmd CMD_DEL_FIRST = 3'd5;

    typedef struct packed {
        t_cmd cmd;
        logic capture;
        logic mode_ge;
    } t_cell_ctl;

endpackage

[rtl/bdl_if.sv]
// Valid/ready channel interfaces for the list's operation and result beats.
interface bdl_in_if;
    logic                      valid;
    logic                      ready;
    bdl_pkg::t_kind            kind;
    logic [bdl_pkg::OPV_W-1:0] operand_value;

    modport source (output valid, output kind, output operand_value, input ready);
    modport sink   (input valid, input kind, input operand_value, output ready);
endinterface

interface bdl_out_if #(
    parameter int OCC_W = bdl_pkg::OCC_W_DEF
);
    logic                      valid;
    logic                      ready;
    logic [bdl_pkg::OPV_W-1:0] popped_value;
    logic                      found;
    bdl_pkg::t_status          status;
    logic [OCC_W-1:0]          occupancy;

    modport source (output valid, output popped_value, output found, output status,
                    output occupancy, input ready);
    modport sink   (input valid, input popped_value, input found, input status,
                    input occupancy, output ready);
endinterface

[rtl/bdl_cell.sv]
// One slot of the list: holds a value, compares it and shifts with its neighbors.
module bdl_cell #(
    parameter int IDX         = 0,
    parameter int VALUE_WIDTH = bdl_pkg::VALUE_WIDTH_DEF,
    parameter int CNT_W       = bdl_pkg::OCC_W_DEF
) (
    input  logic                   i_clk,
    input  bdl_pkg::t_cell_ctl     i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_opv,
    input  logic [CNT_W-1:0]       i_count,
    input  logic [VALUE_WIDTH-1:0] i_left_val,
    input  logic [VALUE_WIDTH-1:0] i_right_val,
    input  logic                   i_pre,
    input  logic [VALUE_WIDTH-1:0] i_tv,
    output logic [VALUE_WIDTH-1:0] o_val,
    output logic                   o_pre,
    output logic [VALUE_WIDTH-1:0] o_tv
);

    logic [VALUE_WIDTH-1:0] r_val;
    logic [VALUE_WIDTH-1:0] n_val;
    logic                   r_hit;
    logic                   r_pre;
    logic [VALUE_WIDTH-1:0] r_tv;
    logic                   w_occ;
    logic                   w_tail;
    logic                   w_match;

    assign w_occ   = CNT_W'(IDX) < i_count;
    assign w_tail  = CNT_W'(IDX + 1) == i_count;
    assign w_match = i_ctl.mode_ge ? ($signed(r_val) >= $signed(i_opv)) : (r_val == i_opv);

    // r_pre tells whether any earlier cell hit; r_tv carries the tail value
    // down the chain. Both settle one cell per cycle.
    assign o_pre = r_pre | r_hit;
    assign o_tv  = w_tail ? r_val : r_tv;
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        case (i_ctl.cmd)
            bdl_pkg::CMD_INS_HEAD: begin
                n_val = (IDX == 0) ? i_opv : i_left_val;
            end
            bdl_pkg::CMD_INS_COUNT: begin
                if (CNT_W'(IDX) == i_count) begin
                    n_val = i_opv;
                end
            end
            bdl_pkg::CMD_INS_FIRST: begin
                if (r_pre) begin
                    n_val = i_left_val;
                end else if (r_hit) begin
                    n_val = i_opv;
                end
            end
            bdl_pkg::CMD_DEL_HEAD: begin
                n_val = i_right_val;
            end
            bdl_pkg::CMD_DEL_FIRST: begin
                if (r_pre | r_hit) begin
                    n_val = i_right_val;
                end
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_pre <= i_pre;
        r_tv  <= i_tv;
        if (i_ctl.capture) begin
            r_hit <= w_occ & w_match;
        end
    end

endmodule

[rtl/bounded_double_ended_list.sv]
// Top level of the bounded double-ended list: sequencer and chain of cells.
//
// Operation beats enter on i_in (kind, operand_value); one result beat per
// operation leaves on o_out (popped_value, found, status, occupancy).
// Operations are handled one at a time. Push head, push tail, pop head and
// the unused code run a compare step, then an apply step that sets result
// valid. Ordered insert, pop tail, remove and query add a scan step between
// compare and apply. The match flags and the tail value ripple through the
// chain one cell per cycle, so the scan step covers the whole chain.
// A new operation is accepted in the cycle after the previous one is
// applied, also while its result still waits in the output register.
// If the receiver stalls, the finished result holds on o_out and the next
// operation waits in its apply step until the output register is free.
// Reset empties the list (count to zero); the slot values stay undefined
// and are never read before they are written. No clearing pass is needed.
module bounded_double_ended_list #(
    parameter int CAPACITY    = bdl_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = bdl_pkg::VALUE_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bdl_in_if.sink     i_in,
    bdl_out_if.source  o_out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int OPV_W = bdl_pkg::OPV_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CMP   = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_APPLY = 2'd3;

    logic [1:0]             r_state;
    bdl_pkg::t_kind         r_kind;
    logic [VALUE_WIDTH-1:0] r_opv;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_scan;

    logic                   r_out_valid;
    logic [OPV_W-1:0]       r_pop;
    logic                   r_found;
    bdl_pkg::t_status       r_status;
    logic [CNT_W-1:0]       r_occ;

    logic [VALUE_WIDTH-1:0] w_opv_in;
    logic                   w_accept;
    logic                   w_fire;
    logic                   w_need_scan;
    logic                   w_full;
    logic                   w_empty;
    logic [VALUE_WIDTH-1:0] w_head;
    logic [VALUE_WIDTH-1:0] w_tail;
    logic                   w_any;

    bdl_pkg::t_cmd          n_cmd;
    logic [CNT_W-1:0]       n_count;
    logic [VALUE_WIDTH-1:0] n_pop;
    logic [OPV_W-1:0]       w_pop_out;
    logic                   n_found;
    bdl_pkg::t_status       n_status;
    bdl_pkg::t_cell_ctl     w_ctl;

    logic [VALUE_WIDTH-1:0] w_val [CAPACITY];
    logic                   w_pre [CAPACITY];
    logic [VALUE_WIDTH-1:0] w_tv  [CAPACITY];

    // The operand is narrowed or sign extended to the stored width; popped
    // values leave zero extended or truncated to the port width.
    generate
        if (VALUE_WIDTH <= OPV_W) begin : g_opv_narrow
            assign w_opv_in = i_in.operand_value[VALUE_WIDTH-1:0];
        end else begin : g_opv_wide
            assign w_opv_in = {{(VALUE_WIDTH - OPV_W){i_in.operand_value[OPV_W-1]}},
                               i_in.operand_value};
        end
        if (VALUE_WIDTH >= OPV_W) begin : g_pop_wide
            assign w_pop_out = n_pop[OPV_W-1:0];
        end else begin : g_pop_narrow
            assign w_pop_out = {{(OPV_W - VALUE_WIDTH){1'b0}}, n_pop};
        end
    endgenerate

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_fire     = (r_state == S_APPLY) && (!r_out_valid || o_out.ready);

    assign w_need_scan = (r_kind == bdl_pkg::K_ORD_INSERT) || (r_kind == bdl_pkg::K_POP_TAIL) ||
                         (r_kind == bdl_pkg::K_REMOVE) || (r_kind == bdl_pkg::K_QUERY);
    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);

    assign w_head = w_val[0];
    assign w_tail = w_tv[CAPACITY-1];
    assign w_any  = w_pre[CAPACITY-1];

    always_comb begin
        n_cmd    = bdl_pkg::CMD_HOLD;
        n_count  = r_count;
        n_pop    = '0;
        n_found  = 1'b0;
        n_status = bdl_pkg::ST_OK;
        case (r_kind)
            bdl_pkg::K_PUSH_HEAD, bdl_pkg::K_PUSH_TAIL, bdl_pkg::K_ORD_INSERT: begin
                if (w_full) begin
                    n_status = bdl_pkg::ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                    if (r_kind == bdl_pkg::K_PUSH_HEAD) begin
                        n_cmd = bdl_pkg::CMD_INS_HEAD;
                    end else if (r_kind == bdl_pkg::K_PUSH_TAIL) begin
                        n_cmd = bdl_pkg::CMD_INS_COUNT;
                    end else if (w_empty || ($signed(r_opv) <= $signed(w_head))) begin
                        n_cmd = bdl_pkg::CMD_INS_HEAD;
                    end else if ($signed(r_opv) >= $signed(w_tail)) begin
                        n_cmd = bdl_pkg::CMD_INS_COUNT;
                    end else begin
                        n_cmd = bdl_pkg::CMD_INS_FIRST;
                    end
                end
            end
            bdl_pkg::K_POP_HEAD, bdl_pkg::K_POP_TAIL: begin
                if (w_empty) begin
                    n_status = bdl_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                    if (r_kind == bdl_pkg::K_POP_HEAD) begin
                        n_pop = w_head;
                        n_cmd = bdl_pkg::CMD_DEL_HEAD;
                    end else begin
                        n_pop = w_tail;
                    end
                end
            end
            bdl_pkg::K_REMOVE: begin
                if (!w_empty) begin
                    if (w_head == r_opv) begin
                        n_cmd   = bdl_pkg::CMD_DEL_HEAD;
                        n_count = r_count - 1'b1;
                        n_found = 1'b1;
                    end else if (w_tail == r_opv) begin
                        // Dropping the tail only shortens the list.
                        n_count = r_count - 1'b1;
                        n_found = 1'b1;
                    end else if (w_any) begin
                        n_cmd   = bdl_pkg::CMD_DEL_FIRST;
                        n_count = r_count - 1'b1;
                        n_found = 1'b1;
                    end
                end
            end
            bdl_pkg::K_QUERY: begin
                n_found = w_any;
            end
            default: begin
                n_cmd = bdl_pkg::CMD_HOLD;
            end
        endcase
    end

    assign w_ctl.cmd     = w_fire ? n_cmd : bdl_pkg::CMD_HOLD;
    assign w_ctl.capture = (r_state == S_CMP);
    assign w_ctl.mode_ge = (r_kind == bdl_pkg::K_ORD_INSERT);

    generate
        for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [VALUE_WIDTH-1:0] w_left;
            logic [VALUE_WIDTH-1:0] w_right;
            logic                   w_pre_in;
            logic [VALUE_WIDTH-1:0] w_tv_in;

            if (gi == 0) begin : g_first
                assign w_left   = r_opv;
                assign w_pre_in = 1'b0;
                assign w_tv_in  = '0;
            end else begin : g_mid
                assign w_left   = w_val[gi-1];
                assign w_pre_in = w_pre[gi-1];
                assign w_tv_in  = w_tv[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign w_right = w_val[gi];
            end else begin : g_inner
                assign w_right = w_val[gi+1];
            end

            bdl_cell #(
                .IDX         (gi),
                .VALUE_WIDTH (VALUE_WIDTH),
                .CNT_W       (CNT_W)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_opv       (r_opv),
                .i_count     (r_count),
                .i_left_val  (w_left),
                .i_right_val (w_right),
                .i_pre       (w_pre_in),
                .i_tv        (w_tv_in),
                .o_val       (w_val[gi]),
                .o_pre       (w_pre[gi]),
                .o_tv        (w_tv[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (w_need_scan) begin
                        r_scan  <= CNT_W'(CAPACITY);
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_APPLY;
                    end
                end
                S_SCAN: begin
                    r_scan <= r_scan - 1'b1;
                    if (r_scan == CNT_W'(1)) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    if (w_fire) begin
                        r_count <= n_count;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_in.kind;
            r_opv  <= w_opv_in;
        end
        if (w_fire) begin
            r_pop    <= w_pop_out;
            r_found  <= n_found;
            r_status <= n_status;
            r_occ    <= n_count;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.popped_value = r_pop;
    assign o_out.found        = r_found;
    assign o_out.status       = r_status;
    assign o_out.occupancy    = r_occ;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_count_only_on_apply : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> $stable(r_count))
        else $error("element count changed outside the apply step");

    a_full_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == bdl_pkg::ST_FULL) |-> o_out.occupancy == CNT_W'(CAPACITY))
        else $error("full status reported on a list that is not full");

    a_empty_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == bdl_pkg::ST_EMPTY) |->
            (o_out.occupancy == '0 && o_out.popped_value == '0))
        else $error("empty status reported on a list that is not empty");

endmodule

[sim/bdl_checker.sv]
// Checker for the bounded double-ended list: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module bdl_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    bdl_in_if    i_op_ch,
    bdl_out_if   i_res_ch,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);
    import bdl_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam int OW  = OCC_W_DEF;

    typedef logic signed [OPV_W-1:0] t_value;

    typedef struct packed {
        logic [OPV_W-1:0] popped;
        logic             found;
        t_status          status;
        logic [OW-1:0]    occupancy;
    } t_outcome;

    // Shadow copy of the list, slot 0 is the head.
    t_value   shadow_list [CAP];
    int       shadow_count = 0;
    t_outcome expected_q [$];
    int       fail_total = 0;
    int       checked_total = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    function automatic void insert_slot(int pos, t_value v);
        int i;
        for (i = shadow_count; i > pos; i--)
            shadow_list[i] = shadow_list[i-1];
        shadow_list[pos] = v;
        shadow_count++;
    endfunction

    function automatic t_value remove_slot(int pos);
        t_value v;
        int     i;
        v = shadow_list[pos];
        for (i = pos; i < shadow_count - 1; i++)
            shadow_list[i] = shadow_list[i+1];
        shadow_count--;
        return v;
    endfunction

    function automatic t_outcome predict_op(t_kind kind, t_value v);
        t_outcome r;
        int       pos;
        int       i;
        r   = '0;
        pos = -1;
        case (kind)
            K_PUSH_HEAD, K_PUSH_TAIL, K_ORD_INSERT: begin
                if (shadow_count >= CAP) begin
                    r.status = ST_FULL;
                end else begin
                    if (kind == K_PUSH_HEAD) begin
                        pos = 0;
                    end else if (kind == K_PUSH_TAIL) begin
                        pos = shadow_count;
                    end else if (shadow_count == 0 || v <= shadow_list[0]) begin
                        pos = 0;
                    end else if (v >= shadow_list[shadow_count-1]) begin
                        pos = shadow_count;
                    end else begin
                        // The tail is larger than v here, so the scan stops inside.
                        pos = 0;
                        while (shadow_list[pos] < v)
                            pos++;
                    end
                    insert_slot(pos, v);
                end
            end
            K_POP_HEAD, K_POP_TAIL: begin
                if (shadow_count == 0)
                    r.status = ST_EMPTY;
                else
                    r.popped = remove_slot(kind == K_POP_HEAD ? 0 : shadow_count - 1);
            end
            K_REMOVE: begin
                if (shadow_count > 0) begin
                    // Head first, then tail, then the first match from the head side.
                    if (shadow_list[0] == v) begin
                        pos = 0;
                    end else if (shadow_list[shadow_count-1] == v) begin
                        pos = shadow_count - 1;
                    end else begin
                        for (i = 1; i < shadow_count; i++) begin
                            if (pos < 0 && shadow_list[i] == v)
                                pos = i;
                        end
                    end
                    if (pos >= 0) begin
                        void'(remove_slot(pos));
                        r.found = 1'b1;
                    end
                end
            end
            K_QUERY: begin
                for (i = 0; i < shadow_count; i++) begin
                    if (shadow_list[i] == v)
                        r.found = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.occupancy = shadow_count[OW-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        $display("MISMATCH %s: expected 0x%08h, got 0x%08h (result %0d)",
                 what, want, got, checked_total);
        fail_total++;
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            shadow_count = 0;
            expected_q.delete();
        end else begin
            // Results are handled before new operations, so a beat never meets
            // the expectation of an operation accepted at the same edge.
            if (i_res_ch.valid && i_res_ch.ready) begin
                if (expected_q.size() == 0) begin
                    flag_mismatch("result beat with nothing outstanding", 32'd0,
                                  i_res_ch.popped_value);
                end else begin
                    want = expected_q.pop_front();
                    if (i_res_ch.popped_value !== want.popped)
                        flag_mismatch("popped_value", want.popped, i_res_ch.popped_value);
                    if (i_res_ch.found !== want.found)
                        flag_mismatch("found", 32'(want.found), 32'(i_res_ch.found));
                    if (i_res_ch.status !== want.status)
                        flag_mismatch("status", 32'(want.status), 32'(i_res_ch.status));
                    if (i_res_ch.occupancy !== want.occupancy)
                        flag_mismatch("occupancy", 32'(want.occupancy),
                                      32'(i_res_ch.occupancy));
                end
                checked_total++;
            end
            if (i_op_ch.valid && i_op_ch.ready)
                expected_q.push_back(predict_op(i_op_ch.kind, i_op_ch.operand_value));
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_q.size();
        o_checked    <= checked_total;
    end

endmodule

[sim/testbench.sv]
// Top of the list testbench: clock, reset, operation stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module testbench;
    import bdl_pkg::*;

    localparam t_kind K_UNUSED    = 3'd7;
    localparam int    CYCLE_LIMIT = 400000;
    localparam int    ITEM_TARGET = 1150;
    localparam int    DRAIN_WAIT  = CAPACITY_DEF + 8;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} t_phase;
    typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC} t_stall_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int fail_count;
    int pending;
    int checked;
    int cycle_count = 0;
    int sent_total = 0;
    int burst_left = 0;

    logic [31:0] recent_vals [8];

    bdl_in_if  u_in_if ();
    bdl_out_if u_out_if ();

    bounded_double_ended_list u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in_if),
        .o_out   (u_out_if)
    );

    bdl_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op_ch      (u_in_if),
        .i_res_ch     (u_out_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: switches between free flow, random stalls and a periodic stall.
    initial begin : res_ready_gen
        t_stall_mode mode;
        int          span;
        int          tick;
        u_out_if.ready <= 1'b0;
        mode = RX_FREE;
        span = 0;
        tick = 0;
        forever begin
            @(posedge i_clk);
            if (span == 0) begin
                mode = t_stall_mode'($urandom_range(0, 2));
                span = $urandom_range(40, 240);
                tick = 0;
            end
            span--;
            tick++;
            case (mode)
                RX_FREE:   u_out_if.ready <= 1'b1;
                RX_RANDOM: u_out_if.ready <= ($urandom_range(0, 3) != 0);
                default:   u_out_if.ready <= ((tick % 11) < 7);
            endcase
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2: return recent_vals[$urandom_range(0, 7)];
            3, 4:    return $urandom_range(0, 8) - 4;
            5: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    function automatic t_kind pick_kind(t_phase ph);
        int r;
        r = $urandom_range(0, 99);
        case (ph)
            PH_FILL: begin
                if (r < 30)      return K_ORD_INSERT;
                else if (r < 50) return K_PUSH_HEAD;
                else if (r < 70) return K_PUSH_TAIL;
                else if (r < 82) return K_QUERY;
                else if (r < 92) return K_REMOVE;
                else if (r < 96) return K_POP_HEAD;
                else             return K_POP_TAIL;
            end
            PH_DRAIN: begin
                if (r < 25)      return K_POP_HEAD;
                else if (r < 50) return K_POP_TAIL;
                else if (r < 72) return K_REMOVE;
                else if (r < 84) return K_QUERY;
                else if (r < 90) return K_ORD_INSERT;
                else if (r < 95) return K_PUSH_HEAD;
                else             return K_PUSH_TAIL;
            end
            default: begin
                if (r < 3) return K_UNUSED;
                return t_kind'($urandom_range(0, 6));
            end
        endcase
    endfunction

    // Drives one operation beat and returns at the edge where it is taken.
    // Beats go out in bursts; between bursts valid may drop for a random gap.
    task automatic send_op(input t_kind k, input logic [31:0] v);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                u_in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        u_in_if.valid         <= 1'b1;
        u_in_if.kind          <= k;
        u_in_if.operand_value <= v;
        @(posedge i_clk);
        while (!u_in_if.ready)
            @(posedge i_clk);
        if (k == K_PUSH_HEAD || k == K_PUSH_TAIL || k == K_ORD_INSERT)
            recent_vals[$urandom_range(0, 7)] = v;
        sent_total++;
    endtask

    initial begin : stimulus
        t_phase ph;
        int     phase_len;
        int     n;
        u_in_if.valid         <= 1'b0;
        u_in_if.kind          <= K_PUSH_HEAD;
        u_in_if.operand_value <= '0;
        i_rst_n               <= 1'b0;
        for (n = 0; n < 8; n++)
            recent_vals[n] = n - 2;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty-store cases and the unused code.
        send_op(K_POP_HEAD, 32'hFFFF_FFFF);
        send_op(K_POP_TAIL, 32'h0000_0000);
        send_op(K_REMOVE, 32'd5);
        send_op(K_QUERY, 32'd0);
        send_op(K_UNUSED, 32'hFFFF_FFFF);
        // Ordered insert into an empty store, then the value extremes.
        send_op(K_ORD_INSERT, 32'd0);
        send_op(K_PUSH_HEAD, 32'h8000_0000);
        send_op(K_PUSH_TAIL, 32'h7FFF_FFFF);
        send_op(K_ORD_INSERT, 32'h8000_0000);
        send_op(K_ORD_INSERT, 32'h7FFF_FFFF);
        send_op(K_ORD_INSERT, 32'd5);
        send_op(K_ORD_INSERT, -32'sd5);
        send_op(K_QUERY, 32'd5);
        send_op(K_QUERY, 32'd6);
        // Remove at the head, the tail, the middle, and a miss.
        send_op(K_REMOVE, 32'h8000_0000);
        send_op(K_REMOVE, 32'h7FFF_FFFF);
        send_op(K_REMOVE, 32'd0);
        send_op(K_REMOVE, 32'd1234);
        send_op(K_POP_TAIL, 32'd0);
        send_op(K_POP_HEAD, 32'd0);

        // Fill phases push the store toward full, drain phases toward empty.
        while (sent_total < ITEM_TARGET) begin
            case ($urandom_range(0, 99) / 34)
                0:       ph = PH_FILL;
                1:       ph = PH_DRAIN;
                default: ph = PH_MIX;
            endcase
            phase_len = $urandom_range(10, 50);
            for (n = 0; n < phase_len; n++)
                send_op(pick_kind(ph), pick_value());
        end
        u_in_if.valid <= 1'b0;

        // The checker's outstanding count is registered, so it lags the queue.
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Summary: %0d operations in directed, fill, drain and mixed phases; %0d results compared.",
                 sent_total, checked);
        $display("Summary: bursty operation input against free, random and periodic result stalls.");
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/bdl_pkg.sv
rtl/bdl_if.sv
rtl/bdl_cell.sv
rtl/bounded_double_ended_list.sv
sim/bdl_checker.sv
sim/testbench.sv
